>>> rtl/core/blepr_pkg.sv
// Shared types, constants and per-byte functions for the BLE advertising receiver.
// Holds the whitening LFSR step, the CRC24 byte update and the result struct.
// No dependencies.
package blepr_pkg;

   localparam logic [7:0]  PREAMBLE_AA  = 8'hAA;
   localparam logic [7:0]  PREAMBLE_55  = 8'h55;
   localparam logic [31:0] ADV_ADDRESS  = 32'hD6BE898E;
   localparam logic [23:0] CRC_POLY     = 24'h00065B;
   localparam logic [7:0]  WHITEN_TAPS  = 8'h11;
   localparam logic [7:0]  SEED_FORCE   = 8'h02;

   localparam int unsigned CSR_INDEX_W  = 4;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITENING_CHANNEL = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_SEED          = 4'd1;

   localparam logic [5:0]  CHANNEL_RESET  = 6'd37;
   localparam logic [23:0] CRC_SEED_RESET = 24'h555555;

   typedef struct packed {
      logic [7:0] lfsr;
      logic [7:0] data;
   } whiten_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] pdu_byte;
      logic       is_last;
      logic       crc_ok;
      logic       phy_2m;
   } result_type;

   function automatic logic [7:0] blepr_rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

   function automatic whiten_type blepr_dewhiten(input logic [7:0] lfsr,
                                                 input logic [7:0] b);
      whiten_type w;
      logic [7:0] s;
      logic [7:0] d;
      s = lfsr;
      d = b;
      for (int i = 0; i < 8; i++) begin
         if (s[7]) begin
            s    = s ^ WHITEN_TAPS;
            d[i] = ~d[i];
         end
         s = {s[6:0], 1'b0};
      end
      w.lfsr = s;
      w.data = d;
      return w;
   endfunction

   function automatic logic [23:0] blepr_crc_feed(input logic [23:0] crc,
                                                  input logic [7:0]  b);
      logic [23:0] c;
      logic        top;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         top = c[23];
         c   = {c[22:0], 1'b0};
         if (b[i] != top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/ble_adv_packet_receiver.sv
// Top level of the BLE advertising packet receiver.
// Holds the request register, the result register and the configuration registers.
// Depends on blepr_pkg and blepr_frame_parser.
//
// The receiver takes one demodulated byte per request and returns one dewhitened
// header, payload or CRC byte per frame byte; preamble and access address bytes
// give no result. A new request can be taken every clock cycle: each byte passes
// through a request register, the unrolled whitening LFSR and CRC24 logic and a
// result register, which drives the result port. The request side stalls only
// while a byte that gives a result waits behind a full result register that is
// not being read. The channel and CRC seed are sampled when the advertising
// access address is matched.
module ble_adv_packet_receiver
   import blepr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_pdu_byte,
   output logic                   rsp_is_last,
   output logic                   rsp_crc_ok,
   output logic                   rsp_phy_2m,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic        out_ok_ff;
   logic        out_phy_ff;
   logic [5:0]  channel_ff;
   logic [23:0] crc_seed_ff;

   result_type  result;
   logic        out_free;
   logic        advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!result.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   blepr_frame_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .rx_byte           (in_byte_ff),
      .whitening_channel (channel_ff),
      .crc_seed          (crc_seed_ff),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         channel_ff   <= CHANNEL_RESET;
         crc_seed_ff  <= CRC_SEED_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && result.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_WHITENING_CHANNEL: channel_ff  <= csr_wdata[5:0];
               CSR_CRC_SEED:          crc_seed_ff <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.emit) begin
         out_byte_ff <= result.pdu_byte;
         out_last_ff <= result.is_last;
         out_ok_ff   <= result.crc_ok;
         out_phy_ff  <= result.phy_2m;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_pdu_byte = out_byte_ff;
   assign rsp_is_last  = out_last_ff;
   assign rsp_crc_ok   = out_ok_ff;
   assign rsp_phy_2m   = out_phy_ff;

endmodule

>>> rtl/core/blepr_frame_parser.sv
// Frame parser: preamble hunt, access address check, dewhitening and CRC24 check.
// Holds all per-frame state and produces at most one result per byte.
// Depends on blepr_pkg.
module blepr_frame_parser
   import blepr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic [5:0]  whitening_channel,
   input  logic [23:0] crc_seed,
   output result_type  result
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ACCESS,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        pending_ff, pending_in;
   logic        is_aa_ff, is_aa_in;
   logic        is_2m_ff, is_2m_in;
   logic [31:0] access_ff, access_in;
   logic [2:0]  access_cnt_ff, access_cnt_in;
   logic [1:0]  header_cnt_ff, header_cnt_in;
   logic [7:0]  remain_ff, remain_in;
   logic [7:0]  lfsr_ff, lfsr_in;
   logic [23:0] crc_ff, crc_in;
   logic [1:0]  crc_cnt_ff, crc_cnt_in;
   logic        mismatch_ff, mismatch_in;

   whiten_type  whiten;
   logic [23:0] crc_next;
   logic [7:0]  crc_slice;
   logic [7:0]  crc_expect;
   logic [7:0]  preamble;
   logic        go_hunt;

   always_comb begin
      whiten   = blepr_dewhiten(lfsr_ff, rx_byte);
      crc_next = blepr_crc_feed(crc_ff, whiten.data);
      case (crc_cnt_ff)
         2'd0:    crc_slice = crc_ff[23:16];
         2'd1:    crc_slice = crc_ff[15:8];
         default: crc_slice = crc_ff[7:0];
      endcase
      crc_expect = blepr_rev8(crc_slice);
      preamble   = is_aa_ff ? PREAMBLE_AA : PREAMBLE_55;

      result.emit     = (phase_ff == PH_HEADER) || (phase_ff == PH_PAYLOAD) ||
                        (phase_ff == PH_CRC);
      result.pdu_byte = whiten.data;
      result.phy_2m   = is_2m_ff;
      result.is_last  = (phase_ff == PH_CRC) && (crc_cnt_ff >= 2'd2);
      result.crc_ok   = result.is_last && !mismatch_ff && (whiten.data == crc_expect);
   end

   always_comb begin
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      is_aa_in      = is_aa_ff;
      is_2m_in      = is_2m_ff;
      access_in     = access_ff;
      access_cnt_in = access_cnt_ff;
      header_cnt_in = header_cnt_ff;
      remain_in     = remain_ff;
      lfsr_in       = lfsr_ff;
      crc_in        = crc_ff;
      crc_cnt_in    = crc_cnt_ff;
      mismatch_in   = mismatch_ff;
      go_hunt       = 1'b0;

      if (step) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (!pending_ff) begin
                  if ((rx_byte == PREAMBLE_AA) || (rx_byte == PREAMBLE_55)) begin
                     pending_in = 1'b1;
                     is_aa_in   = (rx_byte == PREAMBLE_AA);
                  end
               end else begin
                  pending_in = 1'b0;
                  phase_in   = PH_ACCESS;
                  if (rx_byte == preamble) begin
                     is_2m_in      = 1'b1;
                     access_in     = '0;
                     access_cnt_in = 3'd0;
                  end else begin
                     is_2m_in      = 1'b0;
                     access_in     = {24'd0, rx_byte};
                     access_cnt_in = 3'd1;
                  end
               end
            end
            PH_ACCESS: begin
               access_in     = {access_ff[23:0], rx_byte};
               access_cnt_in = access_cnt_ff + 3'd1;
               if (access_cnt_ff >= 3'd3) begin
                  if ((rx_byte[7] != is_aa_ff) || (access_in != ADV_ADDRESS)) begin
                     go_hunt = 1'b1;
                  end else begin
                     phase_in      = PH_HEADER;
                     header_cnt_in = 2'd0;
                     lfsr_in       = blepr_rev8({2'b00, whitening_channel}) | SEED_FORCE;
                     crc_in        = crc_seed;
                  end
               end
            end
            PH_HEADER: begin
               lfsr_in       = whiten.lfsr;
               crc_in        = crc_next;
               header_cnt_in = header_cnt_ff + 2'd1;
               if (header_cnt_ff >= 2'd1) begin
                  remain_in   = whiten.data;
                  crc_cnt_in  = 2'd0;
                  mismatch_in = 1'b0;
                  phase_in    = (whiten.data != 8'd0) ? PH_PAYLOAD : PH_CRC;
               end
            end
            PH_PAYLOAD: begin
               lfsr_in   = whiten.lfsr;
               crc_in    = crc_next;
               remain_in = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  crc_cnt_in  = 2'd0;
                  mismatch_in = 1'b0;
                  phase_in    = PH_CRC;
               end
            end
            PH_CRC: begin
               lfsr_in    = whiten.lfsr;
               crc_cnt_in = crc_cnt_ff + 2'd1;
               if (whiten.data != crc_expect) begin
                  mismatch_in = 1'b1;
               end
               if (crc_cnt_ff >= 2'd2) begin
                  go_hunt = 1'b1;
               end
            end
            default: begin
               go_hunt = 1'b1;
            end
         endcase
      end

      if (go_hunt) begin
         phase_in      = PH_HUNT;
         pending_in    = 1'b0;
         is_aa_in      = 1'b0;
         is_2m_in      = 1'b0;
         access_in     = '0;
         access_cnt_in = '0;
         header_cnt_in = '0;
         remain_in     = '0;
         lfsr_in       = '0;
         crc_in        = '0;
         crc_cnt_in    = '0;
         mismatch_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         pending_ff    <= 1'b0;
         is_aa_ff      <= 1'b0;
         is_2m_ff      <= 1'b0;
         access_ff     <= '0;
         access_cnt_ff <= '0;
         header_cnt_ff <= '0;
         remain_ff     <= '0;
         lfsr_ff       <= '0;
         crc_ff        <= '0;
         crc_cnt_ff    <= '0;
         mismatch_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pending_ff    <= pending_in;
         is_aa_ff      <= is_aa_in;
         is_2m_ff      <= is_2m_in;
         access_ff     <= access_in;
         access_cnt_ff <= access_cnt_in;
         header_cnt_ff <= header_cnt_in;
         remain_ff     <= remain_in;
         lfsr_ff       <= lfsr_in;
         crc_ff        <= crc_in;
         crc_cnt_ff    <= crc_cnt_in;
         mismatch_ff   <= mismatch_in;
      end
   end

endmodule
